/* rtl/core/grid_trilinear_interpolator_assert.svh */
// Assertion macros for the grid interpolator modules.
// No dependencies; included by the files that carry assertions.
`ifndef GRID_TRILINEAR_INTERPOLATOR_ASSERT_SVH
`define GRID_TRILINEAR_INTERPOLATOR_ASSERT_SVH
// Checks that a condition implies a consequence in the same cycle.
`define GTI_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Checks that a condition implies a consequence in the next cycle.
`define GTI_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* rtl/core/gti_pkg.sv */
// Package of the grid interpolator: widths, register indexes and the
// request record that passes from the front end to the back end.
package gti_pkg;
    localparam int GRID_DEPTH_DEF  = 65536;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SIZE_W = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REG_NUM_DIMS = 3'd0;
    localparam logic [2:0] REG_SIZE_X   = 3'd1;
    localparam logic [2:0] REG_SIZE_Y   = 3'd2;
    localparam logic [2:0] REG_SIZE_Z   = 3'd3;
    localparam logic [2:0] REG_SCALE_X  = 3'd4;
    localparam logic [2:0] REG_SCALE_Y  = 3'd5;
    localparam logic [2:0] REG_SCALE_Z  = 3'd6;

    // One axis after classification: corners and weight.
    typedef struct packed {
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
        logic [15:0]       frac;
    } t_axis;

    typedef struct packed {
        logic               is_query;
        logic               three_d;
        logic               sat;
        logic [15:0]        index;
        logic signed [31:0] value;
        t_axis              ax;
        t_axis              ay;
        t_axis              az;
    } t_req;

    // Rounded Q16 step: floor((d*f + 32768) / 65536).
    function automatic logic signed [32:0] round_q16(input logic signed [49:0] t);
        logic signed [49:0] s;
        begin
            s = t + 50'sd32768;
            round_q16 = s[48:16];
        end
    endfunction
endpackage

/* rtl/core/gti_front.sv */
// Front end of the grid interpolator: takes requests, multiplies each axis
// position of a query by its scale in turn and builds the corner record.
// Depends on gti_pkg.
module gti_front import gti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [15:0]        i_sample_index,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic [1:0]         i_num_dims,
    input  logic [SIZE_W-1:0]  i_size_x,
    input  logic [SIZE_W-1:0]  i_size_y,
    input  logic [SIZE_W-1:0]  i_size_z,
    input  logic [31:0]        i_scale_x,
    input  logic [31:0]        i_scale_y,
    input  logic [31:0]        i_scale_z,
    output logic               o_req_valid,
    input  logic               i_req_ready,
    output t_req               o_req
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DONE} t_state;
    t_state            r_state;
    logic [1:0]        r_axis;
    t_req              r_req;
    logic [31:0]       r_px, r_py, r_pz;
    logic [63:0]       r_prod;
    logic              r_prod_v;
    logic [1:0]        r_prod_axis;
    logic [31:0]       w_pos, w_scale;
    logic [SIZE_W-1:0] w_size, w_top;
    logic [31:0]       w_ip;
    t_axis             w_ax;
    logic              w_sat;

    assign o_ready     = (r_state == S_IDLE);
    assign o_req_valid = (r_state == S_DONE);
    assign o_req       = r_req;

    always_comb begin
        case (r_axis)
            2'd0:    begin w_pos = r_px; w_scale = i_scale_x; end
            2'd1:    begin w_pos = r_py; w_scale = i_scale_y; end
            default: begin w_pos = r_pz; w_scale = i_scale_z; end
        endcase
        case (r_prod_axis)
            2'd0:    w_size = i_size_x;
            2'd1:    w_size = i_size_y;
            default: w_size = i_size_z;
        endcase
        w_top = (w_size == '0) ? '0 : w_size - 1'b1;
        w_ip  = r_prod[63:32];
        w_sat = w_ip > {21'd0, w_top};
        w_ax.lo   = w_sat ? w_top : w_ip[SIZE_W-1:0];
        w_ax.hi   = (w_ax.lo == w_top) ? w_top : w_ax.lo + 1'b1;
        w_ax.frac = r_prod[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prod_v <= 1'b0;
        end else begin
            r_prod      <= w_pos * w_scale;
            r_prod_axis <= r_axis;
            case (r_state)
                S_IDLE: begin
                    r_prod_v <= 1'b0;
                    if (i_valid) begin
                        r_req.is_query <= i_mode;
                        r_req.three_d  <= (i_num_dims == 2'd3);
                        r_req.sat      <= 1'b0;
                        r_req.index    <= i_sample_index;
                        r_req.value    <= i_sample_value;
                        r_px <= i_pos_x; r_py <= i_pos_y; r_pz <= i_pos_z;
                        r_axis  <= 2'd0;
                        r_state <= i_mode ? S_MUL : S_DONE;
                    end
                end
                S_MUL: begin
                    r_prod_v <= (r_axis != 2'd3);
                    if (r_axis != 2'd3) r_axis <= r_axis + 1'b1;
                    if (r_prod_v) begin
                        r_req.sat <= r_req.sat | (w_sat & (r_prod_axis != 2'd2
                                     || r_req.three_d));
                        case (r_prod_axis)
                            2'd0:    r_req.ax <= w_ax;
                            2'd1:    r_req.ay <= w_ax;
                            default: r_req.az <= w_ax;
                        endcase
                        if (r_prod_axis == 2'd2) r_state <= S_DONE;
                    end
                end
                S_DONE: if (i_req_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/gti_queue.sv */
// Short request queue between front and back end of the interpolator.
// Depends on gti_pkg.
module gti_queue import gti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_req o_data
);
    `include "grid_trilinear_interpolator_assert.svh"
    t_req r_mem [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid & o_ready;
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    `GTI_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QUEUE_DEPTH))
    `GTI_ASSERT_NEXT(a_push_only, i_clk, i_rst_n, w_push && !w_pop, r_cnt != 2'd0)
    `GTI_ASSERT_IMP(a_ptr_eq, i_clk, i_rst_n, r_cnt == 2'd0 || r_cnt == 2'd2,
                    r_wp == r_rp)
endmodule

/* rtl/core/gti_back.sv */
// Back end of the interpolator: owns the grid memory, performs writes and
// runs the corner reads of a query one after another with a shared blend unit.
// Depends on gti_pkg.
module gti_back import gti_pkg::*; #(
    parameter int GRID_DEPTH  = GRID_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_req               i_req,
    input  logic [SIZE_W-1:0]  i_size_y,
    input  logic [SIZE_W-1:0]  i_size_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_interp_value,
    output logic               o_clamped
);
    localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    typedef enum logic [2:0] {S_IDLE, S_ROW, S_ADDR, S_READ, S_BLEND, S_OUT} t_state;

    logic signed [VALUE_WIDTH-1:0] r_mem [GRID_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd;
    t_state r_state;
    t_req   r_req;
    logic [3:0]  r_k;        // corner counter, bit0=x, bit1=y, bit2=z
    logic [21:0] r_row [4];  // row = x*ny + y for (x,y) combos
    logic [1:0]  r_rk;
    logic [31:0] r_addr;
    logic        r_rd_v;
    logic [2:0]  r_rd_k;
    logic signed [31:0] r_c [8];
    logic [2:0]  r_bk;
    logic signed [31:0] r_out;
    logic        r_out_v, r_clamp;
    logic [SIZE_W-1:0] w_ny, w_nz, w_x, w_y, w_z;
    logic signed [31:0] w_a, w_b, w_l;
    logic signed [32:0] w_d;
    logic signed [49:0] w_t;
    logic [15:0] w_f;
    logic signed [VALUE_WIDTH-1:0] w_wr;

    assign w_ny = (i_size_y == '0) ? SIZE_W'(1) : i_size_y;
    assign w_nz = (i_size_z == '0) ? SIZE_W'(1) : i_size_z;
    assign w_x  = r_rk[0] ? r_req.ax.hi : r_req.ax.lo;
    assign w_y  = r_rk[1] ? r_req.ay.hi : r_req.ay.lo;
    assign w_z  = r_k[2]  ? r_req.az.hi : r_req.az.lo;
    assign w_wr = VALUE_WIDTH'($signed(i_req.value[SW-1:0]));
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_interp_value = r_out;
    assign o_clamped = r_clamp;

    // Blend schedule: x pairs into slots 0..3, then y pairs, then z.
    always_comb begin
        case (r_bk)
            3'd0: begin w_a = r_c[0]; w_b = r_c[1]; w_f = r_req.ax.frac; end
            3'd1: begin w_a = r_c[2]; w_b = r_c[3]; w_f = r_req.ax.frac; end
            3'd2: begin w_a = r_c[4]; w_b = r_c[5]; w_f = r_req.ax.frac; end
            3'd3: begin w_a = r_c[6]; w_b = r_c[7]; w_f = r_req.ax.frac; end
            3'd4: begin w_a = r_c[0]; w_b = r_c[1]; w_f = r_req.ay.frac; end
            3'd5: begin w_a = r_c[2]; w_b = r_c[3]; w_f = r_req.ay.frac; end
            default: begin w_a = r_c[0]; w_b = r_c[1]; w_f = r_req.az.frac; end
        endcase
        w_d = 33'(w_b) - 33'(w_a);
        w_t = 50'(w_d) * $signed({1'b0, w_f});
        w_l = 32'(33'(w_a) + round_q16(w_t));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !i_req.is_query
            && 32'(i_req.index) < 32'(GRID_DEPTH))
            r_mem[AW'(i_req.index)] <= w_wr;
        r_rd <= r_mem[AW'(r_addr)];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            r_rd_v <= (r_state == S_READ);
            case (r_state)
                S_IDLE: if (i_valid && i_req.is_query) begin
                    r_req <= i_req; r_rk <= 2'd0; r_state <= S_ROW;
                end
                S_ROW: begin
                    r_row[r_rk] <= 22'(w_x) * 22'(w_ny) + 22'(w_y);
                    r_rk <= r_rk + 1'b1;
                    if (r_rk == 2'd3) begin r_k <= 4'd0; r_state <= S_ADDR; end
                end
                S_ADDR: begin
                    r_addr <= 32'(r_req.three_d ? 32'(r_row[r_k[1:0]] * w_nz)
                              + 32'(w_z) : 32'(r_row[r_k[1:0]]));
                    r_rd_k <= r_k[2:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_k <= r_k + 1'b1;
                    r_state <= ((r_k == 4'd7) || (!r_req.three_d && r_k == 4'd3))
                               ? S_BLEND : S_ADDR;
                end
                S_BLEND: begin
                    // The first cycle here waits for the last corner to land.
                    if (r_rd_v) begin
                        r_bk <= 3'd0;
                    end else begin
                        case (r_bk)
                            3'd0: r_c[0] <= w_l;
                            3'd1: r_c[1] <= w_l;
                            3'd2: r_c[2] <= w_l;
                            3'd3: r_c[3] <= w_l;
                            3'd4: r_c[0] <= w_l;
                            3'd5: r_c[1] <= w_l;
                            default: r_c[0] <= w_l;
                        endcase
                        if ((r_bk == 3'd6) || (!r_req.three_d && r_bk == 3'd4)) begin
                            r_state <= S_OUT;
                        end else if (!r_req.three_d && r_bk == 3'd1) begin
                            r_bk <= 3'd4;
                        end else begin
                            r_bk <= r_bk + 1'b1;
                        end
                    end
                end
                S_OUT: if (!r_out_v) begin
                    r_out <= r_c[0]; r_clamp <= r_req.sat;
                    r_out_v <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // Corner k = z*4 + y*2 + x lands in its slot in the cycle after the read.
            if (r_rd_v) begin
                r_c[r_req.three_d ? {r_rd_k[2], r_rd_k[1], r_rd_k[0]}
                                  : {1'b0, r_rd_k[1], r_rd_k[0]}] <= 32'(r_rd);
            end
        end
    end
endmodule

/* rtl/core/grid_trilinear_interpolator.sv */
// Top level of the grid interpolator: configuration registers, front end,
// request queue and back end. Depends on gti_pkg and the gti_* modules.
//
// A write request stores one sample once it passes the front end, the queue
// and the back end, and the front end takes a new request only after it has
// handed the last one on to the queue. A query request passes these steps in
// order: the front end forms three position products through one multiplier
// and hands the request off; the back end takes it from the queue, forms four
// row products, then an address and a read for each corner (eight corners in
// 3-D, four in 2-D), waits for the last read to land, runs one blend after
// another (seven in 3-D, three in 2-D) and loads the output register. The
// grid memory, read once per corner, and the shared blend multiplier set the
// pace of a query. The front end classifies the next request while the back
// end works, the queue between them holds two requests, and a finished
// result waits in its output register while new requests are taken.
module grid_trilinear_interpolator import gti_pkg::*; #(
    parameter int GRID_DEPTH  = GRID_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [15:0]        i_sample_index,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_interp_value,
    output logic               o_clamped
);
    logic [1:0]        r_num_dims;
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [31:0]       r_scale_x, r_scale_y, r_scale_z;
    logic f_valid, f_ready, b_valid, b_ready;
    t_req f_req, b_req;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 2'd3;
            r_size_x <= SIZE_W'(16); r_size_y <= SIZE_W'(16); r_size_z <= SIZE_W'(16);
            r_scale_x <= 32'h10000; r_scale_y <= 32'h10000; r_scale_z <= 32'h10000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_DIMS: r_num_dims <= i_cfg_data[1:0];
                REG_SIZE_X:   r_size_x   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:   r_size_y   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:   r_size_z   <= i_cfg_data[SIZE_W-1:0];
                REG_SCALE_X:  r_scale_x  <= i_cfg_data;
                REG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                REG_SCALE_Z:  r_scale_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gti_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_sample_index,
        .i_sample_value, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_num_dims(r_num_dims), .i_size_x(r_size_x), .i_size_y(r_size_y),
        .i_size_z(r_size_z), .i_scale_x(r_scale_x), .i_scale_y(r_scale_y),
        .i_scale_z(r_scale_z), .o_req_valid(f_valid), .i_req_ready(f_ready),
        .o_req(f_req)
    );

    gti_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_req),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(b_req)
    );

    gti_back #(.GRID_DEPTH(GRID_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(b_valid), .o_ready(b_ready), .i_req(b_req),
        .i_size_y(r_size_y), .i_size_z(r_size_z), .o_valid, .i_ready,
        .o_interp_value, .o_clamped
    );
endmodule

/* test/grid_interp_checker.sv */
// Checker for the grid interpolator: watches the configuration port and both
// request channels, predicts each query answer and compares it. Uses gti_pkg.
module grid_interp_checker import gti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_mode,
    input  logic [15:0]        i_sample_index,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_interp_value,
    input  logic               i_clamped,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef struct packed {
        logic signed [31:0] value;
        logic               clamped;
    } t_answer;

    typedef struct {
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned frac;
        logic            sat;
    } t_corner;

    logic signed [31:0] grid_copy [0:65535];
    logic [1:0]         dims;
    logic [10:0]        size_x, size_y, size_z;
    logic [31:0]        scale_x, scale_y, scale_z;
    t_answer            answers_due [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = answers_due.size();

    function automatic longint unsigned eff_size(input logic [10:0] s);
        return (s == 0) ? 64'd1 : 64'(s);
    endfunction

    function automatic t_corner locate(input logic [31:0] pos, input logic [31:0] scale,
                                       input logic [10:0] size);
        t_corner         c;
        longint unsigned prod;
        longint unsigned top;
        prod   = 64'(pos) * 64'(scale);
        top    = eff_size(size) - 1;
        c.lo   = prod >> 32;
        c.frac = (prod >> 16) & 64'hFFFF;
        c.sat  = c.lo > top;
        if (c.sat) begin
            c.lo = top;
        end
        c.hi = (c.lo + 1 > top) ? top : c.lo + 1;
        return c;
    endfunction

    function automatic longint blend(input longint a, input longint b,
                                     input longint unsigned f);
        longint t;
        t = (b - a) * longint'(f) + 32768;
        return a + (t >>> 16);
    endfunction

    function automatic longint sample_at(input longint unsigned addr);
        return longint'(grid_copy[addr[15:0]]);
    endfunction

    function automatic t_answer interpolate(input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz);
        t_corner         cx, cy, cz;
        longint unsigned ny, nz;
        longint          c00, c01, c10, c11, r;
        t_answer         ans;
        cx = locate(px, scale_x, size_x);
        cy = locate(py, scale_y, size_y);
        ny = eff_size(size_y);
        nz = eff_size(size_z);
        if (dims == 2'd3) begin
            cz  = locate(pz, scale_z, size_z);
            c00 = blend(sample_at((cx.lo * ny + cy.lo) * nz + cz.lo),
                        sample_at((cx.hi * ny + cy.lo) * nz + cz.lo), cx.frac);
            c01 = blend(sample_at((cx.lo * ny + cy.lo) * nz + cz.hi),
                        sample_at((cx.hi * ny + cy.lo) * nz + cz.hi), cx.frac);
            c10 = blend(sample_at((cx.lo * ny + cy.hi) * nz + cz.lo),
                        sample_at((cx.hi * ny + cy.hi) * nz + cz.lo), cx.frac);
            c11 = blend(sample_at((cx.lo * ny + cy.hi) * nz + cz.hi),
                        sample_at((cx.hi * ny + cy.hi) * nz + cz.hi), cx.frac);
            r   = blend(blend(c00, c10, cy.frac), blend(c01, c11, cy.frac), cz.frac);
            ans.clamped = cx.sat | cy.sat | cz.sat;
        end else begin
            c00 = blend(sample_at(cx.lo * ny + cy.lo), sample_at(cx.hi * ny + cy.lo), cx.frac);
            c10 = blend(sample_at(cx.lo * ny + cy.hi), sample_at(cx.hi * ny + cy.hi), cx.frac);
            r   = blend(c00, c10, cy.frac);
            ans.clamped = cx.sat | cy.sat;
        end
        ans.value = r[31:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            dims    <= 2'd3;
            size_x  <= 11'd16;
            size_y  <= 11'd16;
            size_z  <= 11'd16;
            scale_x <= 32'h10000;
            scale_y <= 32'h10000;
            scale_z <= 32'h10000;
            fails   <= 0;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NUM_DIMS: dims    <= i_cfg_data[1:0];
                    REG_SIZE_X:   size_x  <= i_cfg_data[10:0];
                    REG_SIZE_Y:   size_y  <= i_cfg_data[10:0];
                    REG_SIZE_Z:   size_z  <= i_cfg_data[10:0];
                    REG_SCALE_X:  scale_x <= i_cfg_data;
                    REG_SCALE_Y:  scale_y <= i_cfg_data;
                    REG_SCALE_Z:  scale_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == 1'b0) begin
                    grid_copy[i_sample_index] = i_sample_value;
                end else begin
                    answers_due.push_back(interpolate(i_pos_x, i_pos_y, i_pos_z));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected answer: interp_value %0d clamped %0d",
                           i_interp_value, i_clamped);
                    errs = errs + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want.value !== i_interp_value) begin
                        $error("interp_value mismatch: expected %0d actual %0d",
                               want.value, i_interp_value);
                        errs = errs + 1;
                    end
                    if (want.clamped !== i_clamped) begin
                        $error("clamped mismatch: expected %0d actual %0d",
                               want.clamped, i_clamped);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) begin
                fails <= fails + errs;
            end
        end
    end
endmodule

/* test/grid_trilinear_interpolator_tb.sv */
// Top of the grid interpolator testbench: clock, reset, stimulus and verdict.
// Depends on gti_pkg, grid_trilinear_interpolator and grid_interp_checker.
module grid_trilinear_interpolator_tb;
    import gti_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [15:0]        sample_index;
    logic signed [31:0] sample_value;
    logic [31:0]        pos_x, pos_y, pos_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] interp_value;
    logic               clamped;
    int                 fail_count;
    int                 pending;

    // Our own copy of the sizes and scales, used only to aim query positions
    // at the inside of the grid.
    logic [10:0]        aim_size [3];
    logic [31:0]        aim_scale [3];
    bit                 calm;          // no idling on either side
    int                 stall_left;

    grid_trilinear_interpolator u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_mode         (mode),
        .i_sample_index (sample_index),
        .i_sample_value (sample_value),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pos_z        (pos_z),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_interp_value (interp_value),
        .o_clamped      (clamped)
    );

    grid_interp_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_mode         (mode),
        .i_sample_index (sample_index),
        .i_sample_value (sample_value),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pos_z        (pos_z),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_interp_value (interp_value),
        .i_clamped      (clamped),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result side: ready comes in random bursts of stalls and of acceptance.
    // Stalls stop once the final quiet stretch of the run begins.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (calm) begin
            out_ready = 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready  = ~out_ready;
            stall_left = $urandom_range(1, 14);
        end
    end

    // Writes one configuration register; the block is idle whenever this runs.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            REG_SIZE_X:  aim_size[0]  = data[10:0];
            REG_SIZE_Y:  aim_size[1]  = data[10:0];
            REG_SIZE_Z:  aim_size[2]  = data[10:0];
            REG_SCALE_X: aim_scale[0] = data;
            REG_SCALE_Y: aim_scale[1] = data;
            REG_SCALE_Z: aim_scale[2] = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Presents one request and holds it until the block takes it. Valid is
    // left high afterwards, so a request that follows at once keeps it high.
    task automatic send(input logic m, input logic [15:0] idx, input logic [31:0] val,
                        input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
        @(negedge clk);
        in_valid     = 1'b1;
        mode         = m;
        sample_index = idx;
        sample_value = val;
        pos_x        = px;
        pos_y        = py;
        pos_z        = pz;
        do begin
            @(posedge clk);
        end while (!in_ready);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            repeat (n) begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
    endtask

    // Mostly positions whose grid coordinate lies within or just past the
    // grid; now and then the full range or its ends.
    function automatic logic [31:0] aim(input int axis_no);
        longint unsigned coord;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick < 2 || aim_scale[axis_no] == 0) begin
            return $urandom;
        end else if (pick == 2) begin
            return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        coord = (64'($urandom_range(0, aim_size[axis_no])) << 16) | 64'($urandom_range(0, 16'hFFFF));
        coord = ((coord << 16) + aim_scale[axis_no] - 1) / aim_scale[axis_no];
        return (coord > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : coord[31:0];
    endfunction

    // Writes land mostly in the filled low part of the store, so that they
    // change samples that queries read.
    task automatic random_request();
        logic [15:0] widx;
        widx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 511));
        if ($urandom_range(0, 99) < 35) begin
            send(1'b0, widx, $urandom, $urandom, $urandom, $urandom);
        end else begin
            send(1'b1, 16'($urandom), $urandom, aim(0), aim(1), aim(2));
        end
        sender_gap();
    endtask

    // Waits until every query answer has come back, then leaves room for the
    // last write still inside the block.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_phase(input logic [1:0] d, input logic [10:0] sx, input logic [10:0] sy,
                             input logic [10:0] sz, input logic [31:0] kx,
                             input logic [31:0] ky, input logic [31:0] kz);
        write_reg(REG_NUM_DIMS, 32'(d));
        write_reg(REG_SIZE_X, 32'(sx));
        write_reg(REG_SIZE_Y, 32'(sy));
        write_reg(REG_SIZE_Z, 32'(sz));
        write_reg(REG_SCALE_X, kx);
        write_reg(REG_SCALE_Y, ky);
        write_reg(REG_SCALE_Z, kz);
    endtask

    initial begin
        int i;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_NUM_DIMS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = 1'b0;
        sample_index = '0;
        sample_value = '0;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        out_ready    = 1'b1;
        stall_left   = 0;
        calm         = 1'b1;
        aim_size     = '{11'd16, 11'd16, 11'd16};
        aim_scale    = '{32'h10000, 32'h10000, 32'h10000};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the low 512 entries first. Every query below keeps all its
        // corner addresses inside them, so no query reads an unwritten entry.
        for (i = 0; i < 512; i++) begin
            send(1'b0, 16'(i), $urandom, $urandom, $urandom, $urandom);
        end

        // Directed requests under the reset settings: extreme samples around
        // the origin, positions at zero, at the last grid point along y and z,
        // just past the end and at the top of the range. The x coordinate
        // stays below one so that the corners stay in the filled part.
        send(1'b0, 16'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send(1'b0, 16'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(1'b0, 16'd16, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        send(1'b0, 16'd256, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        send(1'b1, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        send(1'b1, 16'h0, 32'h0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send(1'b1, 16'h0, 32'h0, 32'h0000_C000, 32'h000F_FFFF, 32'h000F_8000);
        send(1'b1, 16'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0);
        send(1'b1, 16'h0, 32'h0, 32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        // A write to the unused register index must change nothing.
        write_reg(3'd7, 32'hFFFF_FFFF);
        send(1'b1, 16'h0, 32'h0, 32'h0000_FFFF, 32'h0001_0000, 32'h0000_0001);
        // Bilinear with a zero x size, the largest x scale and the smallest nonzero y scale.
        drain();
        set_phase(2'd2, 11'd0, 11'd1024, 11'd1024, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
        send(1'b1, 16'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
        send(1'b1, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        // Every phase keeps its grid within the filled 512 entries.
        calm = 1'b0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_phase(2'd3, 11'd8, 11'd8, 11'd8, 32'h10000, 32'h10000, 32'h10000);
                1: set_phase(2'd2, 11'd16, 11'd32, 11'd1024, 32'h10000, 32'h4000, 32'h10000);
                2: set_phase(2'd3, 11'd4, 11'd4, 11'd4, 32'h8000, 32'h8000, 32'h18000);
                3: set_phase(2'd0, 11'd0, 11'd0, 11'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF);
                4: set_phase(2'd1, 11'd3, 11'd7, 11'd2, 32'h0, 32'h10000, 32'h10000);
                5: set_phase(2'd2, 11'd1, 11'd500, 11'd2047, 32'h10000, 32'h10000,
                             32'h10000);
                6: set_phase(2'd3, 11'd1, 11'd1, 11'd1, 32'h10000, 32'h0, 32'hFFFF_FFFF);
                default: set_phase(2'd3, 11'd5, 11'd3, 11'd9, 32'h18000, 32'h20000, 32'h10000);
            endcase
            // The last phase runs with no idling on either side.
            if (ph == 7) begin
                calm = 1'b1;
            end
            repeat (34) random_request();
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
